FILE: sv/srp_pkg.sv
// Shared types and constants for the shelf rectangle packer.
package srp_pkg;

    localparam int DIM_W  = 13;   // atlas and rectangle dimensions
    localparam int PDIM_W = 14;   // padded dimension
    localparam int SUM_W  = 15;   // dimension plus padded dimension
    localparam int POS_W  = 12;
    localparam int AREA_W = 25;
    localparam int PROD_W = 2 * DIM_W;
    localparam int STAT_W = 3;

    localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

    localparam logic [STAT_W-1:0] ST_PLACED     = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD_SIZE   = 3'd1;
    localparam logic [STAT_W-1:0] ST_TOO_LARGE  = 3'd2;
    localparam logic [STAT_W-1:0] ST_ATLAS_FULL = 3'd3;
    localparam logic [STAT_W-1:0] ST_TABLE_FULL = 3'd4;
    localparam logic [STAT_W-1:0] ST_CLEARED    = 3'd5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic REG_ATLAS_WIDTH  = 1'b0;
    localparam logic REG_ATLAS_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_SCAN_END,
        S_DECIDE,
        S_EMIT
    } t_state;

    // One shelf table entry.
    typedef struct packed {
        logic [DIM_W-1:0] top;
        logic [DIM_W-1:0] tall;
        logic [DIM_W-1:0] fill;
    } t_shelf;

endpackage

FILE: sv/srp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/shelf_rect_packer.sv
// Shelf rectangle packer: best-fit shelf placement into a fixed-size atlas.
//
// Each insert pads the rectangle by PADDING pixels on every side and places
// it into the open shelf that has room across and wastes the least height
// (earliest shelf on a tie); if none fits, a new shelf opens below the last
// one if there is room. A clear (operation 1) empties the shelf table and the
// used-area count. Every input transfer gives exactly one result transfer.
// The shelf table lives in a single RAM with a registered read port; the
// search walks it one shelf per cycle and a single compare unit keeps the
// running best candidate. An insert into an empty table skips the search;
// clears and size-rejected inserts go straight to the result. The input is
// stalled while an item is in work; a finished result sits in the output
// register and the next item may be accepted while it waits. The user must
// write the atlas width and height registers through the config port only
// while the block is idle; the block itself does not enforce this. Values
// above MAX_DIM are clamped to MAX_DIM. No clearing pass is needed after
// reset: only shelves below the open count are ever read.
module shelf_rect_packer
    import srp_pkg::*;
#(
    parameter int MAX_SHELVES = 64,
    parameter int PADDING     = 1,
    parameter int MAX_DIM     = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input item channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_operation,
    input  logic [DIM_W-1:0]     i_rect_width,
    input  logic [DIM_W-1:0]     i_rect_height,
    // result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [STAT_W-1:0]    o_status,
    output logic [POS_W-1:0]     o_pos_x,
    output logic [POS_W-1:0]     o_pos_y,
    output logic [AREA_W-1:0]    o_used_area,
    output logic [DIM_W-1:0]     o_remaining_height,
    // config write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    localparam int AW = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
    localparam int CW = $clog2(MAX_SHELVES + 1);
    localparam logic [CW-1:0]     MAX_CNT   = CW'(MAX_SHELVES);
    localparam logic [SUM_W-1:0]  MAX_DIM_V = SUM_W'(MAX_DIM);
    localparam logic [DIM_W-1:0]  RST_DIM   = DIM_W'((MAX_DIM < 1024) ? MAX_DIM : 1024);
    localparam logic [PDIM_W-1:0] PAD2      = PDIM_W'(2 * PADDING);
    localparam logic [SUM_W-1:0]  PAD1      = SUM_W'(PADDING);
    localparam int SW = $bits(t_shelf);

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    t_state              r_state, n_state;
    logic [DIM_W-1:0]    r_atlas_w, n_atlas_w;
    logic [DIM_W-1:0]    r_atlas_h, n_atlas_h;
    logic [CW-1:0]       r_count, n_count;      // open shelves
    logic [AREA_W-1:0]   r_area, n_area;        // used area
    logic [DIM_W-1:0]    r_bottom, n_bottom;    // bottom edge of last shelf
    logic                r_out_valid, n_out_valid;
    logic                r_rd_vld, n_rd_vld;    // RAM read data valid

    logic                r_op, n_op;
    logic [DIM_W-1:0]    r_w, n_w;
    logic [DIM_W-1:0]    r_h, n_h;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [CW-1:0]       r_idx, n_idx;          // scan read index
    logic [AW-1:0]       r_rd_idx, n_rd_idx;    // index of data on RAM output
    logic                r_found, n_found;
    logic [DIM_W-1:0]    r_best_waste, n_best_waste;
    logic [AW-1:0]       r_best_idx, n_best_idx;
    t_shelf              r_best, n_best;
    logic [STAT_W-1:0]   r_status, n_status;
    logic [POS_W-1:0]    r_x, n_x;
    logic [POS_W-1:0]    r_y, n_y;
    logic [STAT_W-1:0]   r_o_status, n_o_status;
    logic [POS_W-1:0]    r_o_x, n_o_x;
    logic [POS_W-1:0]    r_o_y, n_o_y;
    logic [AREA_W-1:0]   r_o_area, n_o_area;
    logic [DIM_W-1:0]    r_o_rem, n_o_rem;

    // ---------------------------------------------------------------
    // shelf table
    // ---------------------------------------------------------------
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_shelf        ram_wdata;
    logic [SW-1:0] ram_rdata;
    t_shelf        rd_shelf;

    srp_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_SHELVES)
    ) u_shelf_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd_shelf = t_shelf'(ram_rdata);

    // ---------------------------------------------------------------
    // datapath helpers
    // ---------------------------------------------------------------
    logic              in_xfer;
    logic              out_xfer;
    logic [PDIM_W-1:0] pw, ph;
    logic [SUM_W-1:0]  cfg_ext;
    logic [DIM_W-1:0]  cfg_clamped;
    logic              fit;
    logic [DIM_W-1:0]  waste;
    logic [SUM_W-1:0]  new_bottom;
    logic [AREA_W+1:0] area_sum;

    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = r_out_valid && !i_stall;

    assign pw = PDIM_W'(r_w) + PAD2;
    assign ph = PDIM_W'(r_h) + PAD2;

    assign cfg_ext     = SUM_W'(i_cfg_data);
    assign cfg_clamped = (cfg_ext > MAX_DIM_V) ? DIM_W'(MAX_DIM_V) : i_cfg_data;

    // shared compare unit: does the shelf on the RAM output take this item
    assign fit = (SUM_W'(rd_shelf.fill) + SUM_W'(pw) <= SUM_W'(r_atlas_w))
              && (PDIM_W'(rd_shelf.tall) >= ph);
    assign waste = DIM_W'(PDIM_W'(rd_shelf.tall) - ph);

    assign new_bottom = SUM_W'(r_bottom) + SUM_W'(ph);
    assign area_sum   = (AREA_W+2)'(r_area) + (AREA_W+2)'(r_prod);

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_atlas_w    = r_atlas_w;
        n_atlas_h    = r_atlas_h;
        n_count      = r_count;
        n_area       = r_area;
        n_bottom     = r_bottom;
        n_out_valid  = out_xfer ? 1'b0 : r_out_valid;
        n_rd_vld     = 1'b0;
        n_op         = r_op;
        n_w          = r_w;
        n_h          = r_h;
        n_prod       = r_prod;
        n_idx        = r_idx;
        n_rd_idx     = r_idx[AW-1:0];
        n_found      = r_found;
        n_best_waste = r_best_waste;
        n_best_idx   = r_best_idx;
        n_best       = r_best;
        n_status     = r_status;
        n_x          = r_x;
        n_y          = r_y;
        n_o_status   = r_o_status;
        n_o_x        = r_o_x;
        n_o_y        = r_o_y;
        n_o_area     = r_o_area;
        n_o_rem      = r_o_rem;
        ram_we       = 1'b0;
        ram_waddr    = r_count[AW-1:0];
        ram_wdata    = '{top: r_bottom, tall: DIM_W'(ph), fill: DIM_W'(pw)};

        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ATLAS_WIDTH:  n_atlas_w = cfg_clamped;
                REG_ATLAS_HEIGHT: n_atlas_h = cfg_clamped;
                default: ;
            endcase
        end

        // best-candidate update whenever a shelf is on the RAM output
        if (r_rd_vld && fit && (!r_found || waste < r_best_waste)) begin
            n_found      = 1'b1;
            n_best_waste = waste;
            n_best_idx   = r_rd_idx;
            n_best       = rd_shelf;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_op    = i_operation;
                    n_w     = i_rect_width;
                    n_h     = i_rect_height;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_prod  = r_w * r_h;
                n_found = 1'b0;
                n_idx   = '0;
                n_x     = '0;
                n_y     = '0;
                n_state = S_EMIT;
                if (r_op == OP_CLEAR) begin
                    n_count  = '0;
                    n_area   = '0;
                    n_bottom = '0;
                    n_status = ST_CLEARED;
                end else if (r_w == '0 || r_h == '0) begin
                    n_status = ST_BAD_SIZE;
                end else if (pw > PDIM_W'(r_atlas_w) || ph > PDIM_W'(r_atlas_h)) begin
                    n_status = ST_TOO_LARGE;
                end else if (r_count == '0) begin
                    n_state = S_DECIDE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // issue one shelf read per cycle
                n_rd_vld = 1'b1;
                if (r_idx == r_count - CW'(1)) begin
                    n_state = S_SCAN_END;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_SCAN_END: begin
                // last shelf is compared this cycle
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = S_EMIT;
                if (r_found) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_best_idx;
                    ram_wdata = '{top:  r_best.top,
                                  tall: r_best.tall,
                                  fill: DIM_W'(SUM_W'(r_best.fill) + SUM_W'(pw))};
                    n_status  = ST_PLACED;
                    n_x       = POS_W'(SUM_W'(r_best.fill) + PAD1);
                    n_y       = POS_W'(SUM_W'(r_best.top) + PAD1);
                    n_area    = (area_sum > (AREA_W+2)'(AREA_MAX)) ? AREA_MAX
                                                                   : AREA_W'(area_sum);
                end else if (new_bottom > SUM_W'(r_atlas_h)) begin
                    n_status = ST_ATLAS_FULL;
                end else if (r_count >= MAX_CNT) begin
                    n_status = ST_TABLE_FULL;
                end else begin
                    // open a new shelf below the last one
                    ram_we   = 1'b1;
                    n_count  = r_count + CW'(1);
                    n_bottom = DIM_W'(new_bottom);
                    n_status = ST_PLACED;
                    n_x      = POS_W'(PAD1);
                    n_y      = POS_W'(SUM_W'(r_bottom) + PAD1);
                    n_area   = (area_sum > (AREA_W+2)'(AREA_MAX)) ? AREA_MAX
                                                                  : AREA_W'(area_sum);
                end
            end
            S_EMIT: begin
                // wait for the output register to free up
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_x       = r_x;
                    n_o_y       = r_y;
                    n_o_area    = r_area;
                    n_o_rem     = (r_atlas_h > r_bottom) ? r_atlas_h - r_bottom : '0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_atlas_w   <= RST_DIM;
            r_atlas_h   <= RST_DIM;
            r_count     <= '0;
            r_area      <= '0;
            r_bottom    <= '0;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_atlas_w   <= n_atlas_w;
            r_atlas_h   <= n_atlas_h;
            r_count     <= n_count;
            r_area      <= n_area;
            r_bottom    <= n_bottom;
            r_out_valid <= n_out_valid;
            r_rd_vld    <= n_rd_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_w          <= n_w;
        r_h          <= n_h;
        r_prod       <= n_prod;
        r_idx        <= n_idx;
        r_rd_idx     <= n_rd_idx;
        r_found      <= n_found;
        r_best_waste <= n_best_waste;
        r_best_idx   <= n_best_idx;
        r_best       <= n_best;
        r_status     <= n_status;
        r_x          <= n_x;
        r_y          <= n_y;
        r_o_status   <= n_o_status;
        r_o_x        <= n_o_x;
        r_o_y        <= n_o_y;
        r_o_area     <= n_o_area;
        r_o_rem      <= n_o_rem;
    end

    assign o_stall            = (r_state != S_IDLE);
    assign o_cfg_ready        = 1'b1;
    assign o_valid            = r_out_valid;
    assign o_status           = r_o_status;
    assign o_pos_x            = r_o_x;
    assign o_pos_y            = r_o_y;
    assign o_used_area        = r_o_area;
    assign o_remaining_height = r_o_rem;

endmodule

FILE: bench/shelf_rect_packer_tb.sv
// Self-checking bench for the shelf rectangle packer: random traffic, local packing model.
`timescale 1ns / 1ps

module shelf_rect_packer_tb
    import srp_pkg::*;
();

    localparam int MAX_SHELVES = 64;
    localparam int PADDING     = 1;
    localparam int MAX_DIM     = 4096;
    localparam int AREA_SUM_W  = PROD_W + 2;
    localparam int ROW_AW      = $clog2(MAX_SHELVES);

    localparam int RANDOM_ITEMS = 1600;
    // Settle gap, long enough for the worst insert (64 open shelves) to finish and leave the block idle.
    localparam int SETTLE_CYCLES = 80;
    // Long result hold-off, enough to back the block up into its input.
    localparam int HOLD_CYCLES = 400;
    // Longest correct quiet stretch: the hold-off or the settle gap, or one item plus a
    // sender gap and a run of result stalls. QUIET_LIMIT is well over any of these.
    localparam int QUIET_LIMIT = 5000;

    // One input transfer.
    typedef struct packed {
        logic             op;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } t_rect_req;

    // One result transfer.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [AREA_W-1:0] used_area;
        logic [DIM_W-1:0]  remaining_height;
    } t_placement;

    typedef enum int {
        PH_MIXED,
        PH_STRIP,
        PH_TINY,
        PH_EXTREME,
        PH_SHRINK
    } t_phase_kind;

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_operation = OP_INSERT;
    logic [DIM_W-1:0]  i_rect_width = '0;
    logic [DIM_W-1:0]  i_rect_height = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [STAT_W-1:0] o_status;
    logic [POS_W-1:0]  o_pos_x;
    logic [POS_W-1:0]  o_pos_y;
    logic [AREA_W-1:0] o_used_area;
    logic [DIM_W-1:0]  o_remaining_height;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_index = REG_ATLAS_WIDTH;
    logic [DIM_W-1:0]  i_cfg_data = '0;

    shelf_rect_packer #(
        .MAX_SHELVES (MAX_SHELVES),
        .PADDING     (PADDING),
        .MAX_DIM     (MAX_DIM)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_operation        (i_operation),
        .i_rect_width       (i_rect_width),
        .i_rect_height      (i_rect_height),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_status           (o_status),
        .o_pos_x            (o_pos_x),
        .o_pos_y            (o_pos_y),
        .o_used_area        (o_used_area),
        .o_remaining_height (o_remaining_height),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    initial begin : clock_gen
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Packing model: own copy of the shelf table, area count and registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]  cfg_width = 13'd1024;
    logic [DIM_W-1:0]  cfg_height = 13'd1024;
    logic [DIM_W-1:0]  row_y    [MAX_SHELVES];
    logic [DIM_W-1:0]  row_h    [MAX_SHELVES];
    logic [DIM_W-1:0]  row_used [MAX_SHELVES];
    logic [6:0]        rows_open = '0;
    logic [AREA_W-1:0] placed_area = '0;

    t_rect_req  rect_backlog[$];    // items waiting for the sender
    t_placement placement_due[$];   // predicted results, oldest first

    int  err_cnt = 0;
    logic item_taken = 1'b0;        // input transfer at the last rising edge
    int  quiet_cycles = 0;
    int  hold_req = 0;
    int  hold_ack = 0;

    // Register values past MAX_DIM act as MAX_DIM.
    function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
        return (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
    endfunction

    // Bottom edge of the lowest open shelf; a new shelf starts here.
    function automatic logic [SUM_W-1:0] rows_bottom();
        if (rows_open == '0) return '0;
        return SUM_W'(row_y[ROW_AW'(rows_open - 7'd1)])
             + SUM_W'(row_h[ROW_AW'(rows_open - 7'd1)]);
    endfunction

    function automatic t_placement pack_rect(t_rect_req req);
        t_placement             res;
        logic [PDIM_W-1:0]      pw;
        logic [PDIM_W-1:0]      ph;
        logic [SUM_W-1:0]       span;
        logic [SUM_W-1:0]       floor_y;
        logic [DIM_W-1:0]       waste;
        logic [DIM_W-1:0]       best_waste;
        logic [AREA_SUM_W-1:0]  area;
        logic [ROW_AW-1:0]      best;
        bit                     found;
        bit                     placed;
        res = '0;
        best = '0;
        best_waste = '0;
        found = 1'b0;
        placed = 1'b0;
        if (req.op == OP_CLEAR) begin
            rows_open = '0;
            placed_area = '0;
            res.status = ST_CLEARED;
        end else if (req.w == '0 || req.h == '0) begin
            res.status = ST_BAD_SIZE;
        end else begin
            pw = PDIM_W'(req.w) + PDIM_W'(2 * PADDING);
            ph = PDIM_W'(req.h) + PDIM_W'(2 * PADDING);
            if (pw > PDIM_W'(cfg_width) || ph > PDIM_W'(cfg_height)) begin
                res.status = ST_TOO_LARGE;
            end else begin
                // best fit: least spare height, first shelf wins a tie
                for (int i = 0; i < int'(rows_open); i++) begin
                    span = SUM_W'(row_used[ROW_AW'(i)]) + SUM_W'(pw);
                    if (span <= SUM_W'(cfg_width) && PDIM_W'(row_h[ROW_AW'(i)]) >= ph) begin
                        waste = row_h[ROW_AW'(i)] - DIM_W'(ph);
                        if (!found || waste < best_waste) begin
                            found = 1'b1;
                            best_waste = waste;
                            best = ROW_AW'(i);
                        end
                    end
                end
                if (found) begin
                    placed = 1'b1;
                end else begin
                    floor_y = rows_bottom();
                    // height check ranks above the table check
                    if (floor_y + SUM_W'(ph) > SUM_W'(cfg_height)) begin
                        res.status = ST_ATLAS_FULL;
                    end else if (int'(rows_open) >= MAX_SHELVES) begin
                        res.status = ST_TABLE_FULL;
                    end else begin
                        best = ROW_AW'(rows_open);
                        row_y[best] = DIM_W'(floor_y);
                        row_h[best] = DIM_W'(ph);
                        row_used[best] = '0;
                        rows_open = rows_open + 7'd1;
                        placed = 1'b1;
                    end
                end
                if (placed) begin
                    res.status = ST_PLACED;
                    res.pos_x = POS_W'(row_used[best] + DIM_W'(PADDING));
                    res.pos_y = POS_W'(row_y[best] + DIM_W'(PADDING));
                    row_used[best] = row_used[best] + DIM_W'(pw);
                    area = AREA_SUM_W'(placed_area)
                         + AREA_SUM_W'(req.w) * AREA_SUM_W'(req.h);
                    placed_area = (area > AREA_SUM_W'(AREA_MAX)) ? AREA_MAX
                                                                 : area[AREA_W-1:0];
                end
            end
        end
        // used area and space below are reported for every outcome
        floor_y = rows_bottom();
        res.used_area = placed_area;
        res.remaining_height = (SUM_W'(cfg_height) > floor_y)
                             ? DIM_W'(SUM_W'(cfg_height) - floor_y) : '0;
        return res;
    endfunction

    task automatic check_field(string name, logic [AREA_W-1:0] want, logic [AREA_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endtask

    // ------------------------------------------------------------------
    // Scoreboard: register writes, result compare, prediction at input transfer
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        t_placement want;
        t_placement pred;
        t_rect_req  seen;
        item_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_ATLAS_WIDTH) cfg_width = clamp_dim(i_cfg_data);
                else cfg_height = clamp_dim(i_cfg_data);
            end
            // a result can never belong to an item taken at this same edge
            if (o_valid && !i_stall) begin
                if (placement_due.size() == 0) begin
                    $error("result transfer with nothing expected, status %0d", o_status);
                    err_cnt++;
                end else begin
                    want = placement_due.pop_front();
                    check_field("status", AREA_W'(want.status), AREA_W'(o_status));
                    check_field("pos_x", AREA_W'(want.pos_x), AREA_W'(o_pos_x));
                    check_field("pos_y", AREA_W'(want.pos_y), AREA_W'(o_pos_y));
                    check_field("used_area", want.used_area, o_used_area);
                    check_field("remaining_height", AREA_W'(want.remaining_height),
                                AREA_W'(o_remaining_height));
                end
            end
            if (i_valid && !o_stall) begin
                seen.op = i_operation;
                seen.w = i_rect_width;
                seen.h = i_rect_height;
                pred = pack_rect(seen);
                placement_due = {placement_due, pred};
            end
        end
    end

    // Anything moving on any channel resets the quiet count.
    always @(posedge i_clk) begin : watchdog
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sender: bursts of random length, random gaps, zero-gap stretches.
    // Valid stays up with a frozen payload until the transfer happens.
    // ------------------------------------------------------------------
    int burst_left = 8;
    int gap_left = 0;

    always @(negedge i_clk) begin : sender
        logic      valid_nxt;
        t_rect_req head;
        valid_nxt = 1'b0;
        if (item_taken) begin
            void'(rect_backlog.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 24);
                gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
            end
        end
        if (i_valid && !item_taken) begin
            valid_nxt = 1'b1;           // still stalled: hold everything
        end else if (gap_left > 0) begin
            gap_left--;
        end else if (rect_backlog.size() != 0) begin
            head = rect_backlog[0];
            valid_nxt = 1'b1;
            i_operation <= head.op;
            i_rect_width <= head.w;
            i_rect_height <= head.h;
        end
        i_valid <= valid_nxt;
    end

    // ------------------------------------------------------------------
    // Result sink: stall pattern runs in random modes of random length; a request
    // from the stimulus starts one long hold-off counted here.
    // ------------------------------------------------------------------
    int hold_left = 0;
    int sink_mode = 0;
    int mode_left = 0;
    int sink_tick = 0;

    always @(negedge i_clk) begin : result_sink
        logic stall_nxt;
        stall_nxt = 1'b0;
        if (hold_ack != hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_ack = hold_req;
        end
        if (hold_left > 0) begin
            hold_left--;
            stall_nxt = 1'b1;
        end else begin
            if (mode_left == 0) begin
                sink_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            sink_tick++;
            case (sink_mode)
                0: stall_nxt = 1'b0;
                1: stall_nxt = ($urandom_range(0, 3) == 0);
                2: stall_nxt = ($urandom_range(0, 9) < 7);
                default: stall_nxt = ((sink_tick % 7) < 3);
            endcase
        end
        i_stall <= stall_nxt;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic add_insert(int w, int h);
        t_rect_req r;
        r.op = OP_INSERT;
        r.w = DIM_W'(w);
        r.h = DIM_W'(h);
        rect_backlog = {rect_backlog, r};
    endtask

    task automatic add_clear();
        t_rect_req r;
        r.op = OP_CLEAR;
        r.w = DIM_W'($urandom_range(0, 8191));
        r.h = DIM_W'($urandom_range(0, 8191));
        rect_backlog = {rect_backlog, r};
    endtask

    // Config writes only happen here, after everything in flight is done.
    task automatic write_reg(logic idx, int value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= DIM_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (rect_backlog.size() != 0 || placement_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic int pick_dim();
        case ($urandom_range(0, 9))
            0: return 1;
            1: return MAX_DIM;
            2: return $urandom_range(MAX_DIM + 1, 8191);
            3: return $urandom_range(1, 16);
            default: return $urandom_range(17, MAX_DIM);
        endcase
    endfunction

    initial begin : stimulus
        t_phase_kind kind;
        int          phase_no;
        int          sent;
        int          n;
        int          r;
        int          aw;
        int          ah;
        int          eff_w;
        int          eff_h;
        int          lim_w;
        int          lim_h;
        phase_no = 0;
        sent = 0;
        aw = 1024;
        ah = 1024;
        eff_w = 1024;
        eff_h = 1024;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pass on the reset atlas (1024 x 1024)
        add_clear();
        add_insert(0, 5);               // zero width
        add_insert(5, 0);               // zero height
        add_insert(0, 0);
        add_insert(8191, 8191);         // all-ones fields, too large
        add_insert(4096, 1);            // too large across
        add_insert(1022, 10);           // padded width exactly fills the atlas
        add_insert(1023, 10);           // one pixel too wide
        add_insert(10, 1022);           // fits the atlas, but no room below: atlas full
        add_insert(10, 8);              // shelf 0 full across: opens shelf 1
        add_insert(10, 5);              // goes into shelf 1 with spare height
        add_insert(20, 10);             // taller than shelf 1, shelf 0 is full across: opens shelf 2
        add_insert(5, 8);               // exact fit in shelf 1 beats shelf 2
        add_clear();
        add_insert(600, 4);
        add_insert(600, 4);             // second equal shelf
        add_insert(10, 2);              // tie on spare height: earliest shelf
        add_insert(1, 1);
        add_insert(1, 1022);            // padded height fills the atlas, but no room below: atlas full
        add_insert(1, 1);
        add_clear();
        drain();

        // Random phases, each under its own atlas setting
        while (sent < RANDOM_ITEMS) begin
            case (phase_no)
                0:       kind = PH_MIXED;
                1, 2:    kind = PH_EXTREME;
                3:       kind = PH_STRIP;
                4:       kind = PH_SHRINK;
                default: kind = t_phase_kind'($urandom_range(0, 4));
            endcase

            case (kind)
                PH_MIXED: begin
                    aw = ($urandom_range(0, 3) == 0) ? pick_dim() : $urandom_range(64, MAX_DIM);
                    ah = ($urandom_range(0, 3) == 0) ? pick_dim() : $urandom_range(64, MAX_DIM);
                end
                PH_STRIP: begin
                    // narrow atlas: one rectangle per shelf, so shelves pile up
                    aw = $urandom_range(3, 80);
                    ah = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 400)
                                                     : $urandom_range(600, 8191);
                end
                PH_TINY: begin
                    aw = $urandom_range(1, 16);
                    ah = $urandom_range(1, 16);
                end
                PH_EXTREME: begin
                    if (phase_no == 1) begin
                        aw = 0;
                        ah = MAX_DIM;
                    end else if (phase_no == 2) begin
                        aw = 8191;
                        ah = 0;
                    end else begin
                        aw = ($urandom_range(0, 4) == 0) ? 0 : pick_dim();
                        ah = ($urandom_range(0, 4) == 0) ? 0 : pick_dim();
                    end
                end
                default: begin
                    // height shrinks under the existing shelves, no clear
                    ah = $urandom_range(0, 64);
                end
            endcase

            if (kind != PH_SHRINK) write_reg(REG_ATLAS_WIDTH, aw);
            write_reg(REG_ATLAS_HEIGHT, ah);
            eff_w = (aw > MAX_DIM) ? MAX_DIM : aw;
            eff_h = (ah > MAX_DIM) ? MAX_DIM : ah;
            lim_w = (eff_w / 6 > 1) ? eff_w / 6 : 1;
            lim_h = (eff_h / 16 > 1) ? eff_h / 16 : 1;

            // first phase: long result hold-off while the sender keeps offering
            if (phase_no == 0) hold_req++;

            case (kind)
                PH_MIXED:   n = $urandom_range(80, 160);
                PH_STRIP:   n = $urandom_range(70, 110);
                PH_TINY:    n = $urandom_range(40, 80);
                default:    n = $urandom_range(20, 40);
            endcase

            if (kind == PH_STRIP) add_clear();
            repeat (n) begin
                r = $urandom_range(0, 99);
                if (r < 3 && kind != PH_STRIP) begin
                    add_clear();
                end else if (r < 7) begin
                    add_insert($urandom_range(0, 8191), $urandom_range(0, 8191));
                end else if (r < 10) begin
                    if (r == 7) add_insert(0, $urandom_range(0, 8191));
                    else add_insert($urandom_range(0, 8191), 0);
                end else begin
                    case (kind)
                        PH_STRIP:
                            add_insert($urandom_range((eff_w > 5) ? eff_w - 4 : 1,
                                                      (eff_w > 3) ? eff_w - 2 : 1),
                                       $urandom_range(1, 6));
                        PH_TINY:
                            add_insert($urandom_range(0, 16), $urandom_range(0, 16));
                        PH_EXTREME:
                            add_insert($urandom_range(1, MAX_DIM), $urandom_range(1, MAX_DIM));
                        default:
                            add_insert($urandom_range(1, lim_w), $urandom_range(1, lim_h));
                    endcase
                end
            end
            sent += n;
            drain();
            phase_no++;
        end

        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/srp_pkg.sv
sv/srp_ram.sv
sv/shelf_rect_packer.sv
bench/shelf_rect_packer_tb.sv
